// ===== src/radio_byte_framer_defines.svh =====
// Assertion macros used by the framer back end.
`ifndef RADIO_BYTE_FRAMER_DEFINES_SVH
`define RADIO_BYTE_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rbf_pkg.sv =====
// Shared types and constants of the radio byte framer.
package rbf_pkg;

  localparam int TX_DEPTH_DEF = 256;
  localparam int FIFO_DEPTH   = 2;

  // Host action codes
  localparam logic [2:0] ACT_CLEAR    = 3'd0;
  localparam logic [2:0] ACT_LOAD     = 3'd1;
  localparam logic [2:0] ACT_START_TX = 3'd2;
  localparam logic [2:0] ACT_REQUEST  = 3'd3;
  localparam logic [2:0] ACT_END_PRE  = 3'd4;
  localparam logic [2:0] ACT_RX_BYTE  = 3'd5;
  localparam logic [2:0] ACT_START_RX = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_RX  = 2'd1;
  localparam logic [1:0] KIND_UFL = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PREAMBLE = 2'd0;
  localparam logic [1:0] CFG_SYNC_HI  = 2'd1;
  localparam logic [1:0] CFG_SYNC_LO  = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_START_TX,
    OP_REQUEST,
    OP_END_PRE,
    OP_RX_BYTE,
    OP_START_RX,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
    logic [7:0] signal_strength;
    logic       extend_preamble;
  } item_t;

  typedef struct packed {
    logic [15:0] preamble_pattern;
    logic [7:0]  sync_high;
    logic [7:0]  sync_low;
  } cfg_t;

endpackage

// ===== src/rbf_front.sv =====
// Front end: accept input words, decode the action and push words with a used action code into the queue.
module rbf_front import rbf_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  in_action_i,
  input  logic [16:0] in_data_i,
  input  logic        full_i,
  output logic        push_o,
  output item_t       push_item_o
);

  op_e op;

  always_comb begin
    case (in_action_i)
      ACT_CLEAR:    op = OP_CLEAR;
      ACT_LOAD:     op = OP_LOAD;
      ACT_START_TX: op = OP_START_TX;
      ACT_REQUEST:  op = OP_REQUEST;
      ACT_END_PRE:  op = OP_END_PRE;
      ACT_RX_BYTE:  op = OP_RX_BYTE;
      ACT_START_RX: op = OP_START_RX;
      default:      op = OP_NONE;
    endcase
  end

  assign in_ready_o = !full_i;

  // Drop words with an unused action code: they change nothing.
  assign push_o = in_valid_i && !full_i && (op != OP_NONE);

  assign push_item_o.op              = op;
  assign push_item_o.data_byte       = in_data_i[7:0];
  assign push_item_o.signal_strength = in_data_i[15:8];
  assign push_item_o.extend_preamble = in_data_i[16];

endmodule

// ===== src/rbf_fifo.sv =====
// Short queue of decoded words between the front end and the back end.
module rbf_fifo import rbf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  localparam int QAW = $clog2(FIFO_DEPTH);
  localparam int QCW = $clog2(FIFO_DEPTH + 1);

  item_t            mem_q [FIFO_DEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]   count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCW'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== src/rbf_back.sv =====
// Back end: framer state, packet buffer, result sequencer and output register.
`include "radio_byte_framer_defines.svh"

module rbf_back import rbf_pkg::*; #(
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        item_valid_i,
  input  item_t       item_i,
  output logic        item_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  out_kind_o,
  output logic        out_last_o,
  output logic [15:0] out_cnt_o
);

  localparam int LW = $clog2(TX_DEPTH);

  typedef enum logic [6:0] {
    PH_PRE0    = 7'b0000001,
    PH_PRE1    = 7'b0000010,
    PH_DEFAULT = 7'b0000100,
    PH_SYNC_HI = 7'b0001000,
    PH_SYNC_LO = 7'b0010000,
    PH_DATA    = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

  phase_e      phase_q, phase_d, data_or_done;
  logic [LW-1:0] len_q, len_d, pos_q, pos_d;
  logic [LW:0]   len_inc, pos_inc;
  logic        stop_q, stop_d;
  logic [7:0]  rx_cnt_q, rx_cnt_d;
  logic [7:0]  pkt_q, pkt_d;
  logic [15:0] ufl_q, ufl_d;

  logic [7:0]  mem_q [TX_DEPTH];
  logic [7:0]  mem_rdata_q;
  logic        wr_en;

  // pending results of the word in flight
  logic        busy_q;
  logic [1:0]  idx_q;
  logic [1:0]  res_n_q, n_new;
  logic [7:0]  res_b0_q, res_b1_q, res_b2_q, b0_new, b1_new, b2_new;
  logic [1:0]  res_kind_q, kind_new;
  logic        res_mem_q, mem_new;
  logic [15:0] res_cnt_q;
  logic        do_ufl;

  logic        out_valid_q, out_last_q;
  logic [7:0]  out_byte_q, cur_byte;
  logic [1:0]  out_kind_q;
  logic [15:0] out_cnt_q;

  logic        load, cur_last, pop;

  assign len_inc      = {1'b0, len_q} + 1'b1;
  assign pos_inc      = {1'b0, pos_q} + 1'b1;
  assign data_or_done = (len_q == '0) ? PH_DONE : PH_DATA;

  assign load     = busy_q && (!out_valid_q || out_ready_i);
  assign cur_last = (idx_q == res_n_q - 2'd1);
  assign pop      = item_valid_i && (!busy_q || (load && cur_last));
  assign item_pop_o = pop;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    pos_d    = pos_q;
    stop_d   = stop_q;
    rx_cnt_d = rx_cnt_q;
    pkt_d    = pkt_q;
    ufl_d    = ufl_q;
    wr_en    = 1'b0;
    do_ufl   = 1'b0;
    n_new    = 2'd0;
    b0_new   = 8'h00;
    b1_new   = 8'h00;
    b2_new   = 8'h00;
    kind_new = KIND_TX;
    mem_new  = 1'b0;
    if (pop) begin
      case (item_i.op)
        OP_CLEAR: len_d = '0;
        OP_LOAD: begin
          if (len_inc < (LW+1)'(TX_DEPTH)) begin
            wr_en = 1'b1;
            len_d = len_inc[LW-1:0];
          end
        end
        OP_START_TX: begin
          pos_d = '0;
          if (cfg_i.preamble_pattern != 16'h0000) begin
            stop_d  = 1'b0;
            phase_d = PH_PRE0;
          end else if (item_i.extend_preamble) begin
            phase_d = PH_DEFAULT;
          end else begin
            phase_d = data_or_done;
          end
        end
        OP_REQUEST: begin
          case (phase_q)
            PH_PRE0: begin
              n_new   = 2'd1;
              b0_new  = cfg_i.preamble_pattern[15:8];
              phase_d = PH_PRE1;
            end
            PH_PRE1: begin
              n_new   = 2'd1;
              b0_new  = cfg_i.preamble_pattern[7:0];
              phase_d = stop_q ? PH_SYNC_HI : PH_PRE0;
            end
            PH_SYNC_HI: begin
              n_new   = 2'd1;
              b0_new  = cfg_i.sync_high;
              phase_d = PH_SYNC_LO;
            end
            PH_SYNC_LO: begin
              n_new   = 2'd1;
              b0_new  = cfg_i.sync_low;
              phase_d = data_or_done;
            end
            PH_DATA: begin
              if (pos_q >= len_q) begin
                do_ufl = 1'b1;
              end else begin
                n_new   = 2'd1;
                mem_new = 1'b1;
                pos_d   = pos_inc[LW-1:0];
                if (pos_inc >= {1'b0, len_q}) begin
                  phase_d = PH_DONE;
                end
              end
            end
            PH_DEFAULT: ;
            default: do_ufl = 1'b1;
          endcase
        end
        OP_END_PRE: begin
          stop_d = 1'b1;
          if (phase_q == PH_DEFAULT) begin
            phase_d = data_or_done;
          end
        end
        OP_RX_BYTE: begin
          kind_new = KIND_RX;
          if (rx_cnt_q == 8'h00) begin
            // header first: signal strength, then packet number
            n_new    = 2'd3;
            b0_new   = item_i.signal_strength;
            b1_new   = pkt_q;
            b2_new   = item_i.data_byte;
            pkt_d    = pkt_q + 8'd1;
            rx_cnt_d = 8'd3;
          end else begin
            n_new    = 2'd1;
            b0_new   = item_i.data_byte;
            rx_cnt_d = rx_cnt_q + 8'd1;
          end
        end
        OP_START_RX: rx_cnt_d = 8'h00;
        default: ;
      endcase
      if (do_ufl) begin
        phase_d  = PH_DONE;
        ufl_d    = ufl_q + 16'd1;
        n_new    = 2'd1;
        b0_new   = 8'h00;
        kind_new = KIND_UFL;
      end
    end
  end

  always_comb begin
    case (idx_q)
      2'd0:    cur_byte = res_mem_q ? mem_rdata_q : res_b0_q;
      2'd1:    cur_byte = res_b1_q;
      default: cur_byte = res_b2_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DONE;
      len_q       <= '0;
      pos_q       <= '0;
      stop_q      <= 1'b0;
      rx_cnt_q    <= 8'h00;
      pkt_q       <= 8'h00;
      ufl_q       <= 16'h0000;
      busy_q      <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      stop_q   <= stop_d;
      rx_cnt_q <= rx_cnt_d;
      pkt_q    <= pkt_d;
      ufl_q    <= ufl_d;
      if (pop) begin
        busy_q <= (n_new != 2'd0);
        idx_q  <= 2'd0;
      end else if (load) begin
        busy_q <= !cur_last;
        idx_q  <= idx_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers and packet buffer
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q] <= item_i.data_byte;
    end
    if (pop) begin
      mem_rdata_q <= mem_q[pos_q];
      res_n_q     <= n_new;
      res_b0_q    <= b0_new;
      res_b1_q    <= b1_new;
      res_b2_q    <= b2_new;
      res_kind_q  <= kind_new;
      res_mem_q   <= mem_new;
      res_cnt_q   <= ufl_d;
    end
    if (load) begin
      out_byte_q <= cur_byte;
      out_kind_q <= res_kind_q;
      out_last_q <= cur_last;
      out_cnt_q  <= res_cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_cnt_o   = out_cnt_q;

  `RBF_ASSERT_IMPL(a_idx_in_range, busy_q, idx_q < res_n_q, "result index past count")
  `RBF_ASSERT_IMPL(a_ufl_word, out_valid_q && (out_kind_q == KIND_UFL), (out_byte_q == 8'h00) && out_last_q, "bad underflow word")
  `RBF_ASSERT_IMPL(a_phase_onehot, 1'b1, $onehot(phase_q), "tx phase not one-hot")
  `RBF_ASSERT_IMPL(a_len_bound, 1'b1, {1'b0, len_q} < (LW+1)'(TX_DEPTH), "tx length past buffer")

endmodule

// ===== src/radio_byte_framer.sv =====
// A word accepted on s_axis passes the queue, the back-end result registers and the output
// register. Throughput: one word per cycle when it gives no result, while no earlier word's
// results wait on m_axis; a received first byte gives three, set by the result sequencer.
// Reset (rst_ni low, async): tx phase done, counters and lengths zero, config to
// defaults; the packet buffer is not cleared and reads as undefined until loaded.
module radio_byte_framer import rbf_pkg::*; #(
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // data_byte[7:0], signal_strength[15:8],
                                     // extend_preamble[16], zero pad[23:17]
  input  logic [2:0]  s_axis_tuser,  // action[2:0]
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // out_byte[7:0], underflow_count[23:8]
  output logic [1:0]  m_axis_tuser,  // kind[1:0]
  output logic        m_axis_tlast,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t        cfg_q;
  logic        push, full, q_valid, q_pop;
  item_t       push_item, q_item;
  logic [7:0]  out_byte;
  logic [15:0] out_cnt;

  // Config writes land at once; the host must write only while the framer is idle; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_pattern <= 16'h0000;
      cfg_q.sync_high        <= 8'hFF;
      cfg_q.sync_low         <= 8'h00;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PREAMBLE: cfg_q.preamble_pattern <= cfg_data_i;
        CFG_SYNC_HI:  cfg_q.sync_high        <= cfg_data_i[7:0];
        CFG_SYNC_LO:  cfg_q.sync_low         <= cfg_data_i[7:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Front end: decode each word and hand those with a used action code to the queue.
  rbf_front u_front (
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_data_i   (s_axis_tdata[16:0]),
    .full_i      (full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  // Queue: lets the host side keep going while results wait on the radio side.
  rbf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  // Back end: tx/rx state, packet buffer and output register.
  rbf_back #(
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .out_kind_o   (m_axis_tuser),
    .out_last_o   (m_axis_tlast),
    .out_cnt_o    (out_cnt)
  );

  assign m_axis_tdata = {out_cnt, out_byte};

endmodule
